@@ rtl/zosp_pkg.sv @@
`default_nettype none
package zosp_pkg;
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 256;
  localparam int unsigned DequeDepth  = 1024;
  localparam int unsigned VtxW   = $clog2(MaxVertices);
  localparam int unsigned CntW   = $clog2(MaxVertices + 1);
  localparam int unsigned EdgeAw = $clog2(MaxEdges);
  localparam int unsigned EdgeCw = $clog2(MaxEdges + 1);
  localparam int unsigned DqAw   = $clog2(DequeDepth);
  localparam int unsigned DqCw   = $clog2(DequeDepth + 1);
  localparam int unsigned DistW  = 7;
  localparam logic [DistW-1:0] Unreach = 7'd127;
  localparam logic [0:0] RegVertexCount = 1'b0;
  localparam logic [0:0] RegSourceVertex = 1'b1;

  typedef struct packed {
    logic [VtxW-1:0] a;
    logic [VtxW-1:0] b;
    logic            w;
  } edge_t;

  // One deque request from the search sequencer.
  typedef struct packed {
    logic            push;
    logic            front;
    logic [VtxW-1:0] v;
  } dq_req_t;
endpackage
`default_nettype wire

@@ rtl/zosp_deque.sv @@
`default_nettype none
module zosp_deque import zosp_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clear_i,
  input  wire dq_req_t         req_i,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output logic                 overflow_o,
  output logic [VtxW-1:0]      head_o
);
  logic [VtxW-1:0] mem [DequeDepth];
  logic [DqAw-1:0] head_q, head_d;
  logic [DqCw-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [DqAw-1:0] wr_addr;
  logic            wr_en;
  logic            full;

  assign full    = (count_q == DqCw'(DequeDepth));
  assign empty_o = (count_q == '0);
  assign overflow_o = ovf_q;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    wr_en   = 1'b0;
    wr_addr = head_q + DqAw'(count_q);
    if (clear_i) begin
      head_d  = '0;
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (pop_i) begin
      head_d  = head_q + 1'b1;
      count_d = count_q - 1'b1;
    end else if (req_i.push) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        wr_en   = 1'b1;
        count_d = count_q + 1'b1;
        if (req_i.front) begin
          head_d  = head_q - 1'b1;
          wr_addr = head_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Registered read of the current head; the sequencer waits in StPop after a change.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= req_i.v;
    head_o <= mem[head_d];
  end
endmodule
`default_nettype wire

@@ rtl/zero_one_shortest_paths_core.sv @@
// 0-1 BFS shortest paths. Edges stream in one item per cycle while tready is
// high and are written to a 256-entry edge memory; endpoints at or beyond
// vertex_count or a full store drop the edge and set edges_dropped on every
// result of that graph. The item with tlast (final_item) starts the search:
// all 64 entries of the distance table are reset, then the source is seeded
// if it is one of the vertices in use. Then a sequencer pops a vertex from a
// 1024-entry deque and walks every stored edge through a single
// add-and-compare unit: fetch, test end a, test end b. When end a is the
// popped vertex, end b is relaxed and the edge is fetched again before end b
// is tested; when end b is, end a is relaxed. Zero-weight improvements go to
// the front of the deque and unit ones to the back. Then one result per
// vertex in use is emitted in ascending order, with tvalid low between
// results; tready stays low from the final item until the last result is
// taken. Deque overflow also sets edges_dropped.
`default_nettype none
module zero_one_shortest_paths_core import zosp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // has_edge, end_a[5:0], end_b[5:0], weight
  input  wire logic        s_axis_tlast,  // final_item
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // vertex[5:0], distance[5:0], unreachable, edges_dropped
  output logic             m_axis_tlast,  // last_vertex
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);
  typedef enum logic [3:0] {
    StLoad, StInit, StSeed, StPop, StPopWait, StEdgeRd, StEdgeChk,
    StRelax, StOut
  } state_e;

  state_e state_q;
  logic [CntW-1:0]   vcount_q;
  logic [VtxW-1:0]   src_q;
  logic [EdgeCw-1:0] etotal_q;
  logic              drop_q;
  logic [CntW-1:0]   count_q;
  logic [VtxW-1:0]   vidx_q;
  logic [EdgeAw-1:0] eidx_q;
  logic              side_q;    // 0: test end a, 1: test end b
  logic [VtxW-1:0]   cur_q;
  logic [DistW-1:0]  curd_q;
  logic [VtxW-1:0]   tgt_q;
  logic              tw_q;
  logic              ovf_lat_q;

  edge_t             edge_mem [MaxEdges];
  edge_t             edge_rd;
  logic [DistW-1:0]  dist_mem [MaxVertices];
  logic [DistW-1:0]  dist_rd;
  logic [VtxW-1:0]   dist_raddr;
  logic              dist_we;
  logic [VtxW-1:0]   dist_waddr;
  logic [DistW-1:0]  dist_wdata;

  logic              dq_clear, dq_pop, dq_empty, dq_ovf;
  dq_req_t           dq_req;
  logic [VtxW-1:0]   dq_head;

  logic              has_edge, in_fire;
  logic [VtxW-1:0]   in_a, in_b;
  logic [CntW-1:0]   live;
  logic              edge_ok;
  logic [DistW-1:0]  nd;

  assign has_edge = s_axis_tdata[0];
  assign in_a     = s_axis_tdata[6:1];
  assign in_b     = s_axis_tdata[12:7];
  assign live     = (vcount_q == '0) ? CntW'(1) :
                    (vcount_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vcount_q;
  assign s_axis_tready = (state_q == StLoad);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign edge_ok  = (CntW'(in_a) < live) && (CntW'(in_b) < live) &&
                    (etotal_q < EdgeCw'(MaxEdges));
  assign cfg_ready_o = 1'b1;

  zosp_deque u_deque (
    .clk_i, .rst_ni, .clear_i(dq_clear), .req_i(dq_req), .pop_i(dq_pop),
    .empty_o(dq_empty), .overflow_o(dq_ovf), .head_o(dq_head)
  );

  // Edge memory: write during load, registered read during search.
  always_ff @(posedge clk_i) begin
    if (in_fire && has_edge && edge_ok) begin
      edge_mem[etotal_q[EdgeAw-1:0]] <= edge_t'({in_a, in_b, s_axis_tdata[13]});
    end
    edge_rd <= edge_mem[eidx_q];
  end

  // Distance table: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rd <= dist_mem[dist_raddr];
  end

  assign nd = curd_q + DistW'(tw_q);

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = vidx_q;
    dist_wdata = Unreach;
    dist_raddr = vidx_q;
    dq_clear   = 1'b0;
    dq_pop     = 1'b0;
    dq_req     = '0;
    case (state_q)
      StLoad: dq_clear = 1'b1;
      StInit: dist_we = 1'b1;
      StSeed: begin
        if (CntW'(src_q) < count_q) begin
          dist_we    = 1'b1;
          dist_waddr = src_q;
          dist_wdata = '0;
          dq_req     = '{push: 1'b1, front: 1'b0, v: src_q};
        end
      end
      StPopWait: begin
        dq_pop     = 1'b1;
        dist_raddr = dq_head;
      end
      StEdgeChk: dist_raddr = side_q ? edge_rd.a : edge_rd.b;
      StRelax: begin
        if (dist_rd > nd) begin
          dist_we    = 1'b1;
          dist_waddr = tgt_q;
          dist_wdata = nd;
          dq_req     = '{push: 1'b1, front: !tw_q, v: tgt_q};
        end
      end
      StOut: dist_raddr = (m_axis_tvalid && m_axis_tready) ? vidx_q + 1'b1 : vidx_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StLoad;
      vcount_q      <= CntW'(MaxVertices);
      src_q         <= '0;
      etotal_q      <= '0;
      drop_q        <= 1'b0;
      count_q       <= '0;
      vidx_q        <= '0;
      eidx_q        <= '0;
      side_q        <= 1'b0;
      cur_q         <= '0;
      curd_q        <= '0;
      tgt_q         <= '0;
      tw_q          <= 1'b0;
      ovf_lat_q     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tlast  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegVertexCount) vcount_q <= cfg_data_i;
        else src_q <= cfg_data_i[VtxW-1:0];
      end
      case (state_q)
        StLoad: begin
          if (in_fire) begin
            if (has_edge) begin
              if (edge_ok) etotal_q <= etotal_q + 1'b1;
              else drop_q <= 1'b1;
            end
            if (s_axis_tlast) begin
              count_q <= live;
              vidx_q  <= '0;
              state_q <= StInit;
            end
          end
        end
        StInit: begin
          // sweep the whole table so later reads never see a stale graph
          vidx_q <= vidx_q + 1'b1;
          if (vidx_q == VtxW'(MaxVertices - 1)) state_q <= StSeed;
        end
        StSeed: state_q <= StPop;
        StPop: begin
          if (dq_empty) begin
            ovf_lat_q <= dq_ovf;
            vidx_q    <= '0;
            state_q   <= StOut;
          end else begin
            state_q <= StPopWait;
          end
        end
        StPopWait: begin
          // head data is valid now; fetch its distance next cycle
          cur_q  <= dq_head;
          eidx_q <= '0;
          side_q <= 1'b0;
          state_q <= (etotal_q == '0) ? StPop : StEdgeRd;
        end
        StEdgeRd: begin
          // the popped vertex's distance is on the read port only right after the pop
          if (eidx_q == '0 && !side_q) curd_q <= dist_rd;
          state_q <= StEdgeChk;
        end
        StEdgeChk: begin
          tw_q  <= edge_rd.w;
          tgt_q <= side_q ? edge_rd.a : edge_rd.b;
          if ((CntW'(edge_rd.a) < count_q) && (CntW'(edge_rd.b) < count_q) &&
              (side_q ? (edge_rd.b == cur_q && edge_rd.a != cur_q)
                      : (edge_rd.a == cur_q))) begin
            state_q <= StRelax;
          end else if (!side_q) begin
            side_q <= 1'b1;
          end else begin
            side_q <= 1'b0;
            if (EdgeCw'(eidx_q) + 1'b1 == etotal_q) state_q <= StPop;
            else begin
              eidx_q  <= eidx_q + 1'b1;
              state_q <= StEdgeRd;
            end
          end
        end
        StRelax: begin
          // curd of the popped vertex may itself improve only via a push later
          if (!side_q) begin
            side_q  <= 1'b1;
            state_q <= StEdgeRd;
          end else begin
            side_q <= 1'b0;
            if (EdgeCw'(eidx_q) + 1'b1 == etotal_q) state_q <= StPop;
            else begin
              eidx_q  <= eidx_q + 1'b1;
              state_q <= StEdgeRd;
            end
          end
        end
        StOut: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, drop_q | ovf_lat_q, dist_rd == Unreach,
                              (dist_rd == Unreach) ? 6'd0 : dist_rd[5:0], vidx_q};
            m_axis_tlast  <= (CntW'(vidx_q) + 1'b1 == count_q);
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              etotal_q <= '0;
              drop_q   <= 1'b0;
              state_q  <= StLoad;
            end else begin
              vidx_q <= vidx_q + 1'b1;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/zosp_checker.sv @@
`default_nettype none
module zosp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  // input is never taken while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");
  // an unreachable result reports distance zero
  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[12]) |-> (m_axis_tdata[11:6] == 6'd0))
    else $error("unreachable with distance");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed while stalled");
  // after a non-last result, next vertex is one higher
  a_ascend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> ##1
    (!m_axis_tvalid || (m_axis_tdata[5:0] == $past(m_axis_tdata[5:0], 2) + 6'd1)))
    else $error("vertex order");
endmodule

bind zero_one_shortest_paths_core zosp_checker u_zosp_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
`default_nettype wire
